@@ design/hea_pkg.sv @@
// ----------------------------------------------------------------------------
// hea_pkg
// shared types and constants of the heat energy accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package hea_pkg;

   localparam logic [18:0] ENERGY_COEF    = 19'd274399;
   localparam int          ENERGY_SHIFT   = 20;
   localparam logic [11:0] SENSOR_INVALID = 12'h7FF;
   localparam logic [6:0]  DIVISOR        = 7'd60;
   // ceil(2^28/60), exact for 22-bit partial dividends below 60*2^16
   localparam logic [22:0] DIV60_RECIP    = 23'd4473925;
   localparam int          DIV60_SHIFT    = 28;

   typedef enum logic [3:0] {
      KIND_TEMP_IN    = 4'd0,
      KIND_TEMP_OUT   = 4'd1,
      KIND_FLOW_AVG   = 4'd2,
      KIND_POWER_AVG  = 4'd3,
      KIND_HOUR_FLOW  = 4'd4,
      KIND_HOUR_DELTA = 4'd5,
      KIND_DAY        = 4'd6,
      KIND_WEEK       = 4'd7,
      KIND_MONTH      = 4'd8
   } report_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_ACCUM,
      ST_EMIT_TIN,
      ST_EMIT_TOUT,
      ST_DIV_FLOW,
      ST_WAIT_FLOW,
      ST_EMIT_FLOW,
      ST_DIV_ENERGY,
      ST_WAIT_ENERGY,
      ST_EMIT_POWER,
      ST_EMIT_HFLOW,
      ST_EMIT_HDELTA,
      ST_DAY_ADD,
      ST_EMIT_DAY,
      ST_EMIT_WEEK,
      ST_EMIT_MONTH
   } state_type;

   typedef struct packed {
      logic            load_in;
      logic            mul1;
      logic            mul2;
      logic            accum;
      logic            div_start;
      logic            div_sel_energy;
      logic            day_add;
      logic            out_load;
      report_kind_type kind;
      logic            last;
   } hea_cmd_type;

   typedef struct packed {
      logic sec0;
      logic min0;
      logic day0;
      logic wday1;
      logic mday1;
      logic div_busy;
      logic out_free;
   } hea_status_type;

endpackage

`default_nettype wire

@@ design/hea_div60.sv @@
// ----------------------------------------------------------------------------
// hea_div60
// divider by 60, sixteen quotient bits per cycle by reciprocal multiply
// ----------------------------------------------------------------------------
`default_nettype none

module hea_div60 #(
   parameter int SUM_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SUM_WIDTH-1:0] dividend,
   output logic                      busy,
   output logic [SUM_WIDTH-1:0]      quotient
);

   localparam int NDIG   = (SUM_WIDTH + 15) / 16;
   localparam int WORK_W = NDIG * 16;
   localparam int CNT_W  = $clog2(NDIG + 1);

   logic [WORK_W-1:0] work_ff, work_in;
   logic [5:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [21:0]       digit;
   logic [43:0]       recip;
   logic [15:0]       qdig;
   logic [21:0]       back;

   always_comb begin
      digit    = {rem_ff, work_ff[WORK_W-1 -: 16]};
      recip    = 44'(digit) * 44'(hea_pkg::DIV60_RECIP);
      qdig     = recip[43:hea_pkg::DIV60_SHIFT];
      back     = digit - 22'(qdig) * 22'(hea_pkg::DIVISOR);
      work_in  = work_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      if (start) begin
         work_in  = WORK_W'(dividend);
         rem_in   = '0;
         count_in = CNT_W'(NDIG);
      end else if (count_ff != '0) begin
         work_in  = {work_ff[WORK_W-17:0], qdig};
         rem_in   = back[5:0];
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         count_ff <= '0;
      end else begin
         rem_ff   <= rem_in;
         count_ff <= count_in;
      end
      work_ff <= work_in;
   end

   assign busy     = (count_ff != '0);
   assign quotient = work_ff[SUM_WIDTH-1:0];

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      {1'b0, rem_ff} < hea_pkg::DIVISOR)
      else $error("divider remainder out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NDIG))
      else $error("divider count out of range");

endmodule

`default_nettype wire

@@ design/hea_datapath.sv @@
// ----------------------------------------------------------------------------
// hea_datapath
// input capture, energy multiply, running sums, divider and output register
// ----------------------------------------------------------------------------
`default_nettype none

module hea_datapath #(
   parameter int SUM_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [11:0]            req_temp_in,
   input  wire logic [11:0]            req_temp_out,
   input  wire logic [23:0]            req_flow_this_second,
   input  wire logic [5:0]             req_second_now,
   input  wire logic [5:0]             req_minute_now,
   input  wire logic [4:0]             req_hour_now,
   input  wire logic [2:0]             req_week_day,
   input  wire logic [4:0]             req_month_day,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_hot_mode,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [3:0]                  rsp_report_kind,
   output logic [31:0]                 rsp_report_value,
   output logic                        rsp_last_report,
   input  wire hea_pkg::hea_cmd_type   cmd,
   output hea_pkg::hea_status_type     status
);

   function automatic logic [SUM_WIDTH-1:0] to_sum(input logic [34:0] v);
      logic [SUM_WIDTH+34:0] t;
      t = {{SUM_WIDTH{1'b0}}, v};
      return t[SUM_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] low32(input logic [SUM_WIDTH-1:0] v);
      logic [SUM_WIDTH+31:0] t;
      t = {32'd0, v};
      return t[31:0];
   endfunction

   logic                 hot_mode_ff;
   logic [11:0]          t_in_ff, t_out_ff;
   logic [23:0]          flow_ff;
   logic                 sec0_ff, min0_ff, day0_ff, wday1_ff, mday1_ff;
   logic [11:0]          dt_ff, dt_in;
   logic [30:0]          prod1_ff, prod1_in;
   logic [54:0]          prod2_ff;
   logic [34:0]          energy;
   logic signed [12:0]   ext_in, ext_out, diff;
   logic [SUM_WIDTH-1:0] mf_ff, me_ff, hd_ff, hf_ff, de_ff, we_ff, mo_ff;
   logic [SUM_WIDTH-1:0] mf_in, me_in, hd_in, hf_in, de_in, we_in, mo_in;
   logic [SUM_WIDTH-1:0] quotient;
   logic                 div_busy;
   logic                 rsp_valid_ff;
   logic [3:0]           kind_ff;
   logic [31:0]          value_ff, value_in;
   logic                 last_ff;

   // temperature difference and energy product
   always_comb begin
      ext_in  = $signed({t_in_ff[11], t_in_ff});
      ext_out = $signed({t_out_ff[11], t_out_ff});
      diff    = hot_mode_ff ? (ext_in - ext_out) : (ext_out - ext_in);
      if (diff[12] || t_in_ff == hea_pkg::SENSOR_INVALID
          || t_out_ff == hea_pkg::SENSOR_INVALID) begin
         dt_in = '0;
      end else begin
         dt_in = diff[11:0];
      end
      prod1_in = 31'(hea_pkg::ENERGY_COEF) * 31'(dt_in);
      energy   = prod2_ff[54:hea_pkg::ENERGY_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         t_in_ff  <= req_temp_in;
         t_out_ff <= req_temp_out;
         flow_ff  <= req_flow_this_second;
         sec0_ff  <= (req_second_now == 6'd0);
         min0_ff  <= (req_second_now == 6'd0) && (req_minute_now == 6'd0);
         day0_ff  <= (req_second_now == 6'd0) && (req_minute_now == 6'd0)
                     && (req_hour_now == 5'd0);
         wday1_ff <= (req_week_day == 3'd1);
         mday1_ff <= (req_month_day == 5'd1);
      end
      if (cmd.mul1) begin
         dt_ff    <= dt_in;
         prod1_ff <= prod1_in;
      end
      if (cmd.mul2) begin
         prod2_ff <= 55'(prod1_ff) * 55'(flow_ff);
      end
   end

   // running sums
   always_comb begin
      mf_in = mf_ff;
      me_in = me_ff;
      hd_in = hd_ff;
      hf_in = hf_ff;
      de_in = de_ff;
      we_in = we_ff;
      mo_in = mo_ff;
      if (cmd.accum) begin
         mf_in = mf_ff + to_sum({11'd0, flow_ff});
         me_in = me_ff + to_sum(energy);
         hd_in = hd_ff + to_sum({23'd0, dt_ff});
         de_in = de_ff + to_sum(energy);
      end
      if (cmd.day_add) begin
         we_in = we_ff + de_ff;
         mo_in = mo_ff + de_ff;
      end
      if (cmd.out_load) begin
         case (cmd.kind)
            hea_pkg::KIND_POWER_AVG: begin
               hf_in = hf_ff + mf_ff;
               mf_in = '0;
               me_in = '0;
            end
            hea_pkg::KIND_HOUR_FLOW:  hf_in = '0;
            hea_pkg::KIND_HOUR_DELTA: hd_in = '0;
            hea_pkg::KIND_DAY:        de_in = '0;
            hea_pkg::KIND_WEEK:       we_in = '0;
            hea_pkg::KIND_MONTH:      mo_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hot_mode_ff <= 1'b0;
         mf_ff       <= '0;
         me_ff       <= '0;
         hd_ff       <= '0;
         hf_ff       <= '0;
         de_ff       <= '0;
         we_ff       <= '0;
         mo_ff       <= '0;
      end else begin
         if (csr_valid) begin
            hot_mode_ff <= csr_hot_mode;
         end
         mf_ff <= mf_in;
         me_ff <= me_in;
         hd_ff <= hd_in;
         hf_ff <= hf_in;
         de_ff <= de_in;
         we_ff <= we_in;
         mo_ff <= mo_in;
      end
   end

   hea_div60 #(
      .SUM_WIDTH(SUM_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(cmd.div_sel_energy ? me_ff : mf_ff),
      .busy    (div_busy),
      .quotient(quotient)
   );

   // report word select
   always_comb begin
      case (cmd.kind) inside
         hea_pkg::KIND_TEMP_IN:    value_in = {{20{t_in_ff[11]}}, t_in_ff};
         hea_pkg::KIND_TEMP_OUT:   value_in = {{20{t_out_ff[11]}}, t_out_ff};
         hea_pkg::KIND_FLOW_AVG,
         hea_pkg::KIND_POWER_AVG:  value_in = low32(quotient);
         hea_pkg::KIND_HOUR_FLOW:  value_in = low32(hf_ff);
         hea_pkg::KIND_HOUR_DELTA: value_in = low32(hd_ff >> 4);
         hea_pkg::KIND_DAY:        value_in = low32(de_ff);
         hea_pkg::KIND_WEEK:       value_in = low32(we_ff);
         hea_pkg::KIND_MONTH:      value_in = low32(mo_ff);
         default:                  value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         kind_ff  <= cmd.kind;
         value_ff <= value_in;
         last_ff  <= cmd.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_kind  = kind_ff;
   assign rsp_report_value = value_ff;
   assign rsp_last_report  = last_ff;

   assign status = '{
      sec0:     sec0_ff,
      min0:     min0_ff,
      day0:     day0_ff,
      wday1:    wday1_ff,
      mday1:    mday1_ff,
      div_busy: div_busy,
      out_free: !rsp_valid_ff || rsp_ready
   };

endmodule

`default_nettype wire

@@ design/hea_ctrl.sv @@
// ----------------------------------------------------------------------------
// hea_ctrl
// sequencer for multiply, accumulate, division and report emission
// ----------------------------------------------------------------------------
`default_nettype none

module hea_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire hea_pkg::hea_status_type status,
   output hea_pkg::hea_cmd_type         cmd
);

   hea_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hea_pkg::ST_IDLE:        if (req_valid) state_in = hea_pkg::ST_MUL1;
         hea_pkg::ST_MUL1:        state_in = hea_pkg::ST_MUL2;
         hea_pkg::ST_MUL2:        state_in = hea_pkg::ST_ACCUM;
         hea_pkg::ST_ACCUM:
            state_in = status.sec0 ? hea_pkg::ST_EMIT_TIN : hea_pkg::ST_IDLE;
         hea_pkg::ST_EMIT_TIN:
            if (status.out_free) state_in = hea_pkg::ST_EMIT_TOUT;
         hea_pkg::ST_EMIT_TOUT:
            if (status.out_free) state_in = hea_pkg::ST_DIV_FLOW;
         hea_pkg::ST_DIV_FLOW:    state_in = hea_pkg::ST_WAIT_FLOW;
         hea_pkg::ST_WAIT_FLOW:
            if (!status.div_busy) state_in = hea_pkg::ST_EMIT_FLOW;
         hea_pkg::ST_EMIT_FLOW:
            if (status.out_free) state_in = hea_pkg::ST_DIV_ENERGY;
         hea_pkg::ST_DIV_ENERGY:  state_in = hea_pkg::ST_WAIT_ENERGY;
         hea_pkg::ST_WAIT_ENERGY:
            if (!status.div_busy) state_in = hea_pkg::ST_EMIT_POWER;
         hea_pkg::ST_EMIT_POWER:
            if (status.out_free) begin
               state_in = status.min0 ? hea_pkg::ST_EMIT_HFLOW : hea_pkg::ST_IDLE;
            end
         hea_pkg::ST_EMIT_HFLOW:
            if (status.out_free) state_in = hea_pkg::ST_EMIT_HDELTA;
         hea_pkg::ST_EMIT_HDELTA:
            if (status.out_free) begin
               state_in = status.day0 ? hea_pkg::ST_DAY_ADD : hea_pkg::ST_IDLE;
            end
         hea_pkg::ST_DAY_ADD:     state_in = hea_pkg::ST_EMIT_DAY;
         hea_pkg::ST_EMIT_DAY:
            if (status.out_free) begin
               if (status.wday1) begin
                  state_in = hea_pkg::ST_EMIT_WEEK;
               end else if (status.mday1) begin
                  state_in = hea_pkg::ST_EMIT_MONTH;
               end else begin
                  state_in = hea_pkg::ST_IDLE;
               end
            end
         hea_pkg::ST_EMIT_WEEK:
            if (status.out_free) begin
               state_in = status.mday1 ? hea_pkg::ST_EMIT_MONTH : hea_pkg::ST_IDLE;
            end
         hea_pkg::ST_EMIT_MONTH:
            if (status.out_free) state_in = hea_pkg::ST_IDLE;
         default:                 state_in = hea_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.kind      = hea_pkg::KIND_TEMP_IN;
      req_ready     = 1'b0;
      unique case (state_ff)
         hea_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         hea_pkg::ST_MUL1:  cmd.mul1  = 1'b1;
         hea_pkg::ST_MUL2:  cmd.mul2  = 1'b1;
         hea_pkg::ST_ACCUM: cmd.accum = 1'b1;
         hea_pkg::ST_EMIT_TIN: begin
            cmd.kind     = hea_pkg::KIND_TEMP_IN;
            cmd.out_load = status.out_free;
         end
         hea_pkg::ST_EMIT_TOUT: begin
            cmd.kind     = hea_pkg::KIND_TEMP_OUT;
            cmd.out_load = status.out_free;
         end
         hea_pkg::ST_DIV_FLOW:  cmd.div_start = 1'b1;
         hea_pkg::ST_WAIT_FLOW: cmd.kind      = hea_pkg::KIND_FLOW_AVG;
         hea_pkg::ST_EMIT_FLOW: begin
            cmd.kind     = hea_pkg::KIND_FLOW_AVG;
            cmd.out_load = status.out_free;
         end
         hea_pkg::ST_DIV_ENERGY: begin
            cmd.div_start      = 1'b1;
            cmd.div_sel_energy = 1'b1;
         end
         hea_pkg::ST_WAIT_ENERGY: cmd.kind = hea_pkg::KIND_POWER_AVG;
         hea_pkg::ST_EMIT_POWER: begin
            cmd.kind     = hea_pkg::KIND_POWER_AVG;
            cmd.out_load = status.out_free;
            cmd.last     = !status.min0;
         end
         hea_pkg::ST_EMIT_HFLOW: begin
            cmd.kind     = hea_pkg::KIND_HOUR_FLOW;
            cmd.out_load = status.out_free;
         end
         hea_pkg::ST_EMIT_HDELTA: begin
            cmd.kind     = hea_pkg::KIND_HOUR_DELTA;
            cmd.out_load = status.out_free;
            cmd.last     = !status.day0;
         end
         hea_pkg::ST_DAY_ADD: cmd.day_add = 1'b1;
         hea_pkg::ST_EMIT_DAY: begin
            cmd.kind     = hea_pkg::KIND_DAY;
            cmd.out_load = status.out_free;
            cmd.last     = !status.wday1 && !status.mday1;
         end
         hea_pkg::ST_EMIT_WEEK: begin
            cmd.kind     = hea_pkg::KIND_WEEK;
            cmd.out_load = status.out_free;
            cmd.last     = !status.mday1;
         end
         hea_pkg::ST_EMIT_MONTH: begin
            cmd.kind     = hea_pkg::KIND_MONTH;
            cmd.out_load = status.out_free;
            cmd.last     = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hea_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider restarted while busy");

   a_last_ends_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && cmd.last |=> state_ff == hea_pkg::ST_IDLE)
      else $error("last word did not end the tick");

endmodule

`default_nettype wire

@@ design/heat_energy_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// heat_energy_accumulator_top
// per-second heat energy accumulation with minute to month reports
// ----------------------------------------------------------------------------
// req_* carries one tick word per second: temperatures, flow and time.
// csr_* writes hot_mode; the user writes it only while the block is idle,
// which the block itself does not enforce; csr_ready is always 1.
// rsp_* returns report words in order, last_report marks the final word of
// a tick. A tick with no boundary returns no word.
// Each tick passes two multiply stages (coefficient times dT, then times
// flow) and one accumulate stage. On a minute boundary two divisions by 60
// run on a divider that settles 16 quotient bits per cycle; an hour boundary
// adds the hour reports and a day boundary the day report, plus the week
// report on week day 1 and the month report on month day 1.
// The last report sits in the output register while the next tick is taken.
// With a word waiting and rsp_ready low the sequencer holds at the next emit
// step; no further tick is taken until all of the tick's reports are loaded.
// Synchronous reset clears all sums, hot_mode and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module heat_energy_accumulator_top #(
   parameter int SUM_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [11:0] req_temp_in,
   input  wire logic [11:0] req_temp_out,
   input  wire logic [23:0] req_flow_this_second,
   input  wire logic [5:0]  req_second_now,
   input  wire logic [5:0]  req_minute_now,
   input  wire logic [4:0]  req_hour_now,
   input  wire logic [2:0]  req_week_day,
   input  wire logic [4:0]  req_month_day,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_hot_mode,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_report_kind,
   output logic [31:0]      rsp_report_value,
   output logic             rsp_last_report
);

   hea_pkg::hea_cmd_type    cmd;
   hea_pkg::hea_status_type status;

   assign csr_ready = 1'b1;

   hea_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   hea_datapath #(
      .SUM_WIDTH(SUM_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_temp_in         (req_temp_in),
      .req_temp_out        (req_temp_out),
      .req_flow_this_second(req_flow_this_second),
      .req_second_now      (req_second_now),
      .req_minute_now      (req_minute_now),
      .req_hour_now        (req_hour_now),
      .req_week_day        (req_week_day),
      .req_month_day       (req_month_day),
      .csr_valid           (csr_valid),
      .csr_hot_mode        (csr_hot_mode),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_report_kind     (rsp_report_kind),
      .rsp_report_value    (rsp_report_value),
      .rsp_last_report     (rsp_last_report),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

`default_nettype wire
